### src/css_pkg.sv
// Shared constants, types and helpers for the crossing switch selector.
package css_pkg;

  localparam int CHANNELS    = 4;
  localparam int CH_W        = $clog2(CHANNELS);
  localparam int SAMPLE_BITS = 16;
  localparam int LEVEL_BITS  = 16;
  localparam int WEIGHT_BITS = 16;
  localparam int PACKED_WTS  = 4;
  localparam int LANES       = 3;
  localparam int LANE_BITS   = 16;
  localparam int TOL_BITS    = 15;
  localparam int PROD_BITS   = 48;
  localparam int PART_BITS   = 32;

  // Input beat layout, lowest field first.
  localparam int EN_OFS     = CHANNELS * SAMPLE_BITS;
  localparam int CONN_OFS   = EN_OFS + CHANNELS;
  localparam int LEVEL_OFS  = CONN_OFS + CHANNELS;
  localparam int LANES_OFS  = LEVEL_OFS + CHANNELS * LEVEL_BITS;
  localparam int IN_RAW_W   = LANES_OFS + LANES * LANE_BITS;
  localparam int IN_DATA_W  = ((IN_RAW_W + 7) / 8) * 8;

  // Output beat layout, lowest field first.
  localparam int O_SEL_OFS   = SAMPLE_BITS;
  localparam int O_GATE_OFS  = O_SEL_OFS + 2;
  localparam int O_EN_OFS    = O_GATE_OFS + CHANNELS;
  localparam int O_PULSE_OFS = O_EN_OFS + CHANNELS;
  localparam int OUT_RAW_W   = O_PULSE_OFS + 1;
  localparam int OUT_DATA_W  = ((OUT_RAW_W + 7) / 8) * 8;

  // Configuration port.
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 64;

  typedef logic signed [SAMPLE_BITS-1:0] sample_t;
  typedef logic signed [LEVEL_BITS-1:0]  level_t;

  // Forced selection coming out of the select triggers.
  typedef struct packed {
    logic            hit;
    logic [CH_W-1:0] ch;
  } force_t;

  // Weight of one channel from a packed register; absent channels weigh full scale.
  function automatic logic [WEIGHT_BITS-1:0] weight_of(logic [CFG_DATA_W-1:0] pw,
                                                       logic [CH_W-1:0] ch);
    logic [WEIGHT_BITS-1:0] w;
    w = '1;
    if (32'(ch) < PACKED_WTS) begin
      w = pw[32'(ch)*WEIGHT_BITS +: WEIGHT_BITS];
    end
    return w;
  endfunction

endpackage

### src/css_schmitt.sv
// Bank of Schmitt triggers on the select lines, producing a forced selection.
module css_schmitt (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              upd,
  input  css_pkg::level_t                   levels [css_pkg::CHANNELS],
  input  logic signed [css_pkg::LEVEL_BITS-1:0] thr_hi,
  input  logic signed [css_pkg::LEVEL_BITS-1:0] thr_lo,
  output css_pkg::force_t                   frc
);
  import css_pkg::*;

  logic [CHANNELS-1:0] trig;
  logic [CHANNELS-1:0] trig_next;

  // Hysteresis per line; the highest rising channel takes the selection.
  always_comb begin
    trig_next = trig;
    frc       = '0;
    for (int i = 0; i < CHANNELS; i++) begin
      if (trig[i]) begin
        if (levels[i] <= thr_lo) trig_next[i] = 1'b0;
      end else if (levels[i] >= thr_hi) begin
        trig_next[i] = 1'b1;
        frc.hit      = 1'b1;
        frc.ch       = CH_W'(i);
      end
    end
  end

  // Trigger states advance once per accepted beat.
  always_ff @(posedge clk) begin
    if (rst) begin
      trig <= '0;
    end else if (upd) begin
      trig <= trig_next;
    end
  end

  // A forced channel always has its trigger high afterwards.
  a_force_sets: assert property (@(posedge clk) disable iff (rst)
    (upd && frc.hit) |=> trig[$past(frc.ch)])
    else $error("forced channel trigger not set");

  a_rise_only_from_low: assert property (@(posedge clk) disable iff (rst)
    (upd && frc.hit) |-> !trig[frc.ch])
    else $error("forced channel was already high");

  a_hold: assert property (@(posedge clk) disable iff (rst)
    !upd |=> $stable(trig))
    else $error("trigger states changed without a beat");

endmodule

### src/css_mul.sv
// Shared 32x16 multiplier with a partial product register.
module css_mul (
  input  logic                             clk,
  input  logic                             ld,
  input  logic [css_pkg::PART_BITS-1:0]    op_a,
  input  logic [css_pkg::WEIGHT_BITS-1:0]  op_b,
  output logic [css_pkg::PROD_BITS-1:0]    prod,
  output logic [css_pkg::PART_BITS-1:0]    prod_q
);
  import css_pkg::*;

  // Full product of the current operands.
  assign prod = {{(PROD_BITS-PART_BITS){1'b0}}, op_a}
              * {{(PROD_BITS-WEIGHT_BITS){1'b0}}, op_b};

  // Hold the first partial product for the second pass.
  always_ff @(posedge clk) begin
    if (ld) begin
      prod_q <= prod[PART_BITS-1:0];
    end
  end

endmodule

### src/crossing_switch_selector.sv
// Top level: channel selector with probabilistic jumps, bans and select triggers.
// A result beat is loaded into the output register in the final state, after all candidate visits.
// Each input beat is finished before the next is taken: each of the three candidate channels
// takes two passes through the one shared 32x16 multiplier, then the output state loads the
// result beat and the idle state takes the next input beat.
// A stalled output holds the sequencer in its final state until the previous beat is taken.
// Reset (rst, synchronous) selects channel 0, clears bans, history, triggers and
// the pulse, and loads the configuration registers with their defaults.
module crossing_switch_selector (
  input  logic                              clk,
  input  logic                              rst,
  // sample_a..d, enable_high_mask, connected_mask, select_level_a..d, random_lanes
  input  logic [css_pkg::IN_DATA_W-1:0]     s_tdata,
  input  logic                              s_tvalid,
  output logic                              s_tready,
  // true_out, selected_channel, gate_mask, enabled_mask, switch_pulse
  output logic [css_pkg::OUT_DATA_W-1:0]    m_tdata,
  output logic                              m_tvalid,
  input  logic                              m_tready,
  input  logic                              cfg_we,
  input  logic [css_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [css_pkg::CFG_DATA_W-1:0]    cfg_data
);
  import css_pkg::*;

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_CA   = 2'd1;
  localparam logic [1:0] ST_CB   = 2'd2;
  localparam logic [1:0] ST_FIN  = 2'd3;

  localparam logic [CFG_IDX_W-1:0] REG_PROB   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_ARR    = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_DEP    = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_TOL    = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_UPDN   = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_PLEN   = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_TRIGHI = 3'd6;
  localparam logic [CFG_IDX_W-1:0] REG_TRIGLO = 3'd7;

  localparam int DIFF_W = SAMPLE_BITS + 1;
  localparam int REL_W  = DIFF_W + 4;

  // Configuration registers.
  logic [WEIGHT_BITS-1:0]        jump_probability;
  logic [CFG_DATA_W-1:0]         arrival_weights;
  logic [CFG_DATA_W-1:0]         departure_weights;
  logic [TOL_BITS-1:0]           match_tolerance;
  logic                          up_down_mode;
  logic [15:0]                   pulse_length;
  logic signed [LEVEL_BITS-1:0]  trigger_high;
  logic signed [LEVEL_BITS-1:0]  trigger_low;

  // Sequencer and item state.
  logic [1:0]                    state;
  logic [CH_W-1:0]               cand;
  logic [CH_W-1:0]               cur_ch;
  logic [CH_W-1:0]               sel;
  logic [CH_W-1:0]               next_ch;
  logic [CHANNELS-1:0]           ban;
  logic [CHANNELS-1:0]           en_q;
  logic [CHANNELS-1:0]           up_q;
  logic [CHANNELS-1:0]           gate_q;
  logic                          fromup;
  logic                          elig;
  logic [15:0]                   pulse_rem;
  logic [LANES*LANE_BITS-1:0]    lanes_q;
  sample_t                       cur_val;
  sample_t                       smp  [CHANNELS];
  sample_t                       prev [CHANNELS];

  // Unpacked input beat.
  sample_t                       in_smp [CHANNELS];
  level_t                        in_lvl [CHANNELS];
  logic [CHANNELS-1:0]           in_en;
  logic [CHANNELS-1:0]           in_up;
  logic [CH_W-1:0]               sel_new;
  force_t                        frc;
  logic                          accept;

  // Candidate evaluation.
  logic [CH_W:0]                 cand_sum;
  logic [CH_W-1:0]               cand_ch;
  sample_t                       cand_val;
  logic [DIFF_W-1:0]             diff;
  logic [REL_W-1:0]              diff_x10;
  logic [REL_W-1:0]              tol_x11;
  logic                          elig_next;
  logic [LANE_BITS-1:0]          draw;
  logic                          jump_win;
  logic                          out_free;

  // Shared multiplier.
  logic [PART_BITS-1:0]          mul_a;
  logic [WEIGHT_BITS-1:0]        mul_b;
  logic [PROD_BITS-1:0]          mul_p;
  logic [PART_BITS-1:0]          mul_q;

  assign accept   = s_tvalid && s_tready;
  assign s_tready = (state == ST_IDLE);
  assign out_free = !m_tvalid || m_tready;

  // Slice the input beat into channels.
  always_comb begin
    for (int i = 0; i < CHANNELS; i++) begin
      in_smp[i] = s_tdata[i*SAMPLE_BITS +: SAMPLE_BITS];
      in_lvl[i] = s_tdata[LEVEL_OFS + i*LEVEL_BITS +: LEVEL_BITS];
      in_en[i]  = s_tdata[EN_OFS + i] && s_tdata[CONN_OFS + i];
      in_up[i]  = in_smp[i] > prev[i];
    end
  end

  css_schmitt u_schmitt (
    .clk    (clk),
    .rst    (rst),
    .upd    (accept),
    .levels (in_lvl),
    .thr_hi (trigger_high),
    .thr_lo (trigger_low),
    .frc    (frc)
  );

  assign sel_new = frc.hit ? frc.ch : cur_ch;

  // Candidate channel: rotate from the selected one.
  always_comb begin
    cand_sum = {1'b0, sel} + {1'b0, cand} + (CH_W+1)'(1);
    if (cand_sum >= (CH_W+1)'(CHANNELS)) begin
      cand_ch = CH_W'(cand_sum - (CH_W+1)'(CHANNELS));
    end else begin
      cand_ch = CH_W'(cand_sum);
    end
  end

  // Distance, ban release and eligibility of the candidate.
  always_comb begin
    cand_val = smp[cand_ch];
    if (cand_val > cur_val) begin
      diff = DIFF_W'({cand_val[SAMPLE_BITS-1], cand_val} - {cur_val[SAMPLE_BITS-1], cur_val});
    end else begin
      diff = DIFF_W'({cur_val[SAMPLE_BITS-1], cur_val} - {cand_val[SAMPLE_BITS-1], cand_val});
    end
    diff_x10  = (REL_W'(diff) << 3) + (REL_W'(diff) << 1);
    tol_x11   = (REL_W'(match_tolerance) << 3) + (REL_W'(match_tolerance) << 1)
              + REL_W'(match_tolerance);
    elig_next = (diff <= DIFF_W'(match_tolerance))
             && !(up_down_mode && (up_q[cand_ch] != fromup))
             && !ban[cand_ch] && en_q[cand_ch];
  end

  // Random draw for this candidate; lanes beyond the supplied ones read zero.
  always_comb begin
    draw = '0;
    if (32'(cand) < LANES) begin
      draw = lanes_q[32'(cand)*LANE_BITS +: LANE_BITS];
    end
  end

  // First pass: probability times arrival weight; second: times departure weight.
  always_comb begin
    if (state == ST_CB) begin
      mul_a = mul_q;
      mul_b = weight_of(departure_weights, sel);
    end else begin
      mul_a = PART_BITS'(jump_probability);
      mul_b = weight_of(arrival_weights, cand_ch);
    end
  end

  css_mul u_mul (
    .clk    (clk),
    .ld     (state == ST_CA),
    .op_a   (mul_a),
    .op_b   (mul_b),
    .prod   (mul_p),
    .prod_q (mul_q)
  );

  assign jump_win = {draw, {(PROD_BITS-LANE_BITS){1'b0}}} < mul_p;

  // Configuration writes.
  always_ff @(posedge clk) begin
    if (rst) begin
      jump_probability  <= 16'd6554;
      arrival_weights   <= '1;
      departure_weights <= '1;
      match_tolerance   <= 15'd102;
      up_down_mode      <= 1'b0;
      pulse_length      <= 16'd48;
      trigger_high      <= 16'sd2048;
      trigger_low       <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_PROB:   jump_probability  <= cfg_data[WEIGHT_BITS-1:0];
        REG_ARR:    arrival_weights   <= cfg_data;
        REG_DEP:    departure_weights <= cfg_data;
        REG_TOL:    match_tolerance   <= cfg_data[TOL_BITS-1:0];
        REG_UPDN:   up_down_mode      <= cfg_data[0];
        REG_PLEN:   pulse_length      <= cfg_data[15:0];
        REG_TRIGHI: trigger_high      <= cfg_data[LEVEL_BITS-1:0];
        REG_TRIGLO: trigger_low       <= cfg_data[LEVEL_BITS-1:0];
        default: ;
      endcase
    end
  end

  // Beat payload captured on accept; candidate eligibility captured in ST_CA.
  always_ff @(posedge clk) begin
    if (accept) begin
      for (int i = 0; i < CHANNELS; i++) begin
        smp[i] <= in_smp[i];
      end
      en_q    <= in_en;
      up_q    <= in_up;
      gate_q  <= CHANNELS'(1) << cur_ch;
      lanes_q <= s_tdata[LANES_OFS +: LANES*LANE_BITS];
      cur_val <= in_smp[sel_new];
      fromup  <= in_up[sel_new];
      sel     <= sel_new;
    end
    if (state == ST_CA) begin
      elig <= elig_next;
    end
  end

  // Sequencer: candidate visits, jump decisions and the output beat.
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      cand      <= '0;
      cur_ch    <= '0;
      next_ch   <= '0;
      ban       <= '0;
      pulse_rem <= '0;
      m_tvalid  <= 1'b0;
      m_tdata   <= '0;
      for (int i = 0; i < CHANNELS; i++) begin
        prev[i] <= '0;
      end
    end else begin
      // A taken beat clears valid unless a new one is loaded in the same cycle.
      if (m_tvalid && m_tready && !(state == ST_FIN && out_free)) m_tvalid <= 1'b0;
      case (state)
        ST_IDLE: begin
          if (accept) begin
            cur_ch  <= sel_new;
            next_ch <= sel_new;
            cand    <= '0;
            state   <= ST_CA;
          end
        end
        ST_CA: begin
          if (ban[cand_ch] && (diff_x10 > tol_x11)) ban[cand_ch] <= 1'b0;
          state <= ST_CB;
        end
        ST_CB: begin
          if (elig) begin
            if (jump_win) begin
              if (pulse_length > pulse_rem) pulse_rem <= pulse_length;
              next_ch  <= cand_ch;
              ban[sel] <= 1'b1;
            end else begin
              ban[cand_ch] <= 1'b1;
            end
          end
          if (32'(cand) == CHANNELS - 2) begin
            state <= ST_FIN;
          end else begin
            cand  <= cand + CH_W'(1);
            state <= ST_CA;
          end
        end
        ST_FIN: begin
          if (out_free) begin
            m_tdata  <= OUT_DATA_W'({(pulse_rem != '0), en_q, gate_q, next_ch, cur_val});
            if (pulse_rem != '0) pulse_rem <= pulse_rem - 16'd1;
            m_tvalid <= 1'b1;
            cur_ch   <= next_ch;
            for (int i = 0; i < CHANNELS; i++) begin
              prev[i] <= smp[i];
            end
            state <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  a_gate_onehot: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> $onehot(m_tdata[O_GATE_OFS +: CHANNELS]))
    else $error("gate mask is not one-hot");

  a_jump_pulse: assert property (@(posedge clk) disable iff (rst)
    (state == ST_CB && elig && jump_win && pulse_length != '0) |=> (pulse_rem != '0))
    else $error("jump did not start the pulse");

  a_jump_bans_source: assert property (@(posedge clk) disable iff (rst)
    (state == ST_CB && elig && jump_win) |=> ban[sel])
    else $error("jump did not ban the source channel");

  a_accept_starts: assert property (@(posedge clk) disable iff (rst)
    accept |=> (state == ST_CA && cand == '0))
    else $error("sequencer did not start on accept");

endmodule
